[hw/rtl/ssdc_pkg.sv]
// shared types and constants for the subarray sum divisible counter
// no dependencies; imported by every other file of the block except ssdc_ram

package ssdc_pkg;

    // field widths
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 32;
    localparam int MOD_W    = 11;
    localparam int HIST_W   = 17;
    localparam int EPOCH_W  = 8;

    // saturation limits
    localparam logic [HIST_W-1:0]  HIST_MAX  = {HIST_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // default histogram depth
    localparam int MAX_MODULUS_DEF = 1024;

    // input transaction payload
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    // result transaction payload
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               done_res;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic read;
        logic commit;
        logic clr_step;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic res_free;
        logic last;
        logic epoch_full;
        logic clr_done;
    } dp_status_t;

endpackage

[hw/rtl/ssdc_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// no dependencies

module ssdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/ssdc_div.sv]
// restoring remainder unit, one quotient bit per cycle
// depends on ssdc_pkg by import only and uses none of its items; standalone arithmetic

module ssdc_div
    import ssdc_pkg::*;
#(
    parameter int MW = 17,
    parameter int KW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] dividend,
    input  logic [KW-1:0] divisor,
    output logic          busy,
    output logic [KW-1:0] rem
);

    localparam int CNT_W = $clog2(MW + 1);

    logic [MW-1:0]    dvd_reg, dvd_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [KW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KW:0]      trial;
    logic [KW:0]      diff;

    // operand load on start, else one restoring step
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[MW-1]};
        diff     = trial - {1'b0, k_reg};
        dvd_next = dvd_reg;
        k_next   = k_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            dvd_next = dividend;
            k_next   = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(MW);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[MW-2:0], 1'b0};
            rem_next = (trial >= {1'b0, k_reg}) ? diff[KW-1:0] : trial[KW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // operand and remainder registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        k_reg   <= k_next;
        rem_reg <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

endmodule

[hw/rtl/ssdc_datapath.sv]
// datapath: modulus register, prefix residue, remainder unit, histogram ram,
// saturating count and result register; uses ssdc_pkg, ssdc_div, ssdc_ram

module ssdc_datapath
    import ssdc_pkg::*;
#(
    parameter int MAX_MODULUS = MAX_MODULUS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [MOD_W-1:0] cfg_wr_data,
    input  item_t            item,
    output result_t          res,
    output logic             res_valid,
    input  logic             res_ready,
    input  dp_cmd_t          cmd,
    output dp_status_t       status
);

    localparam int RW  = $clog2(MAX_MODULUS);
    localparam int KW  = $clog2(MAX_MODULUS + 1);
    localparam int CW  = (MOD_W > KW) ? MOD_W : KW;
    localparam int SW  = ((RW + 1 > VALUE_W + 1) ? RW + 1 : VALUE_W + 1) + 1;
    localparam int MW  = SW - 1;
    localparam int TW  = EPOCH_W + HIST_W;

    logic [MOD_W-1:0]   modulus_reg;
    logic [RW-1:0]      residue_reg, residue_next;
    logic [COUNT_W-1:0] running_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [RW-1:0]      clr_cnt_reg;
    logic               last_reg;
    logic               neg_reg;
    logic [KW-1:0]      k_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    logic [CW-1:0]        mod_w;
    logic [CW-1:0]        k_eff;
    logic signed [SW-1:0] sum;
    logic [SW-1:0]        sum_neg;
    logic [MW-1:0]        mag;
    logic                 div_busy;
    logic [KW-1:0]        div_rem;
    logic [KW-1:0]        fixed_res;
    logic [TW-1:0]        rd_data;
    logic                 tag_hit;
    logic [HIST_W-1:0]    hist;
    logic [HIST_W-1:0]    hist_inc;
    logic [COUNT_W:0]     count_sum;
    logic [COUNT_W-1:0]   count_new;
    logic                 ram_we;
    logic [RW-1:0]        ram_waddr;
    logic [TW-1:0]        ram_wdata;

    // effective modulus, zero taken as one and clamped to the depth
    always_comb
    begin
        mod_w = CW'(modulus_reg);
        if (mod_w == '0)
        begin
            k_eff = CW'(1);
        end
        else if (mod_w > CW'(MAX_MODULUS))
        begin
            k_eff = CW'(MAX_MODULUS);
        end
        else
        begin
            k_eff = mod_w;
        end
    end

    // prefix sum and its magnitude for the remainder unit
    assign sum     = $signed({{(SW - RW){1'b0}}, residue_reg}) + SW'(item.value);
    assign sum_neg = -sum;
    assign mag     = sum[SW-1] ? sum_neg[MW-1:0] : sum[MW-1:0];

    ssdc_div #(
        .MW (MW),
        .KW (KW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (mag),
        .divisor  (k_eff[KW-1:0]),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // true modulo: fold a negative remainder back into range
    assign fixed_res = (neg_reg && (div_rem != '0)) ? (k_reg - div_rem) : div_rem;

    // histogram entry lookup; a stale tag reads as the start-of-array value
    assign tag_hit  = (rd_data[TW-1:HIST_W] == epoch_reg);
    assign hist     = tag_hit ? rd_data[HIST_W-1:0]
                    : ((residue_reg == '0) ? HIST_W'(1) : '0);
    assign hist_inc = (hist < HIST_MAX) ? (hist + HIST_W'(1)) : hist;

    // saturating count
    assign count_sum = {1'b0, running_reg} + (COUNT_W + 1)'(hist);
    assign count_new = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

    // ram write port shared by the clearing sweep and the update
    always_comb
    begin
        ram_we    = cmd.clr_step || cmd.commit;
        ram_waddr = cmd.clr_step ? clr_cnt_reg : residue_reg;
        ram_wdata = cmd.clr_step ? '0 : {epoch_reg, hist_inc};
    end

    ssdc_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_MODULUS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (fixed_res[RW-1:0]),
        .rdata (rd_data)
    );

    // residue next value
    always_comb
    begin
        residue_next = residue_reg;
        if (cmd.read)
        begin
            residue_next = fixed_res[RW-1:0];
        end
        else if (cmd.commit && last_reg)
        begin
            residue_next = '0;
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MOD_W'(1);
            residue_reg   <= '0;
            running_reg   <= '0;
            epoch_reg     <= EPOCH_W'(1);
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                modulus_reg <= cfg_wr_data;
            end
            residue_reg <= residue_next;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= status.clr_done ? '0 : (clr_cnt_reg + RW'(1));
            end
            if (cmd.commit)
            begin
                running_reg <= last_reg ? '0 : count_new;
                if (last_reg)
                begin
                    epoch_reg <= status.epoch_full ? EPOCH_W'(1)
                                                   : (epoch_reg + EPOCH_W'(1));
                end
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            last_reg <= item.last;
            neg_reg  <= sum[SW-1];
            k_reg    <= k_eff[KW-1:0];
        end
        if (cmd.commit)
        begin
            res_reg.count    <= count_new;
            res_reg.done_res <= last_reg;
        end
    end

    // status to the controller
    always_comb
    begin
        status.div_busy   = div_busy;
        status.res_free   = !res_valid_reg || res_ready;
        status.last       = last_reg;
        status.epoch_full = (epoch_reg == {EPOCH_W{1'b1}});
        status.clr_done   = (clr_cnt_reg == RW'(MAX_MODULUS - 1));
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

[hw/rtl/ssdc_ctrl.sv]
// controller state machine: sequences accept, remainder, lookup, update and
// the histogram clearing sweep; uses ssdc_pkg

module ssdc_ctrl
    import ssdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.res_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = (status.last && status.epoch_full) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register, sweep runs first after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/subarray_sum_divisible_counter_core.sv]
// top level of the subarray sum divisible counter: controller plus datapath
// uses ssdc_pkg, ssdc_ctrl, ssdc_datapath
//
//   channel | signals                        | payload
//   --------+--------------------------------+-------------------------
//   item    | item_valid / item_ready        | item_t   (value, last)
//   res     | res_valid / res_ready          | result_t (count, done_res)
//   cfg     | cfg_wr_en (no wait)            | cfg_wr_data = modulus
//
// one item at a time: accept, then one remainder bit per cycle over the
// prefix sum magnitude, then a wait for the remainder unit to finish,
// then a histogram read and a write; only then is the next item taken.
// after reset a clearing sweep over every histogram entry runs before the first
// transaction; the same sweep follows every 255th array end, when the
// histogram epoch tag wraps.
// a finished result waits in the output register while the next item is
// taken; an update stalls only while that register is still full.

module subarray_sum_divisible_counter_core
    import ssdc_pkg::*;
#(
    parameter int MAX_MODULUS = MAX_MODULUS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [MOD_W-1:0] cfg_wr_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    ssdc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // arithmetic and storage
    ssdc_datapath #(
        .MAX_MODULUS (MAX_MODULUS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
